// ===== sv/gpc_pkg.sv =====
// gpc_pkg: widths and control structs shared by the partition-check block.
// No dependencies; compile first.
`default_nettype none

package gpc_pkg;

   // Width of the number under test
   localparam int WIDTH = 16;
   // Trial divisor: d*d <= x stops at d = 2**(WIDTH/2), so one more bit
   localparam int D_W   = WIDTH / 2 + 1;
   // Running square of the divisor, room for (d+1)**2 beyond x
   localparam int SQ_W  = WIDTH + 2;
   // Bit counter of the serial remainder unit
   localparam int CNT_W = $clog2(WIDTH + 1);

   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] dividend;
      logic [D_W-1:0]   divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic is_zero;
   } div_res_type;

   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] value;
   } test_cmd_type;

   typedef struct packed {
      logic done;
      logic is_prime;
   } test_res_type;

endpackage

`default_nettype wire

// ===== sv/gpc_if.sv =====
// gpc_if: request and response channel interfaces (valid/ready handshake).
// Depends on gpc_pkg for the number width.
`default_nettype none

interface gpc_req_if import gpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface gpc_rsp_if ();
   logic valid;
   logic ready;
   logic number_is_prime;
   logic is_two_prime_sum;

   modport source (output valid, output number_is_prime, output is_two_prime_sum,
                   input ready);
   modport sink   (input valid, input number_is_prime, input is_two_prime_sum,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/goldbach_partition_check_top.sv =====
// goldbach_partition_check_top: primality and two-prime-sum check, one item at a time.
// Sequencing: a prime test of x runs one trial divisor at a time through the bit-serial
//   remainder unit, up to floor(sqrt(x))-1 divisors. An item runs one test of n, then, for
//   n of four or more, one test of n-2 for odd n, or pairs of tests (p, n-p) for even n
//   until the first hit or until p passes n/2.
// Throughput: one item in flight; the next is taken once the result sits in the output register.
// Reset: synchronous, active high; clears all control state. No memories, no clearing pass.
`default_nettype none

module goldbach_partition_check_top import gpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gpc_req_if.sink   req_ch,
   gpc_rsp_if.source rsp_ch
);

   // Sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;  // wait for an item
   localparam logic [2:0] S_TEST_N   = 3'd1;  // primality of n itself
   localparam logic [2:0] S_TEST_ODD = 3'd2;  // odd n: only 2 + (n-2) can work
   localparam logic [2:0] S_TEST_P   = 3'd3;  // even n: candidate p
   localparam logic [2:0] S_TEST_Q   = 3'd4;  // even n: partner n-p
   localparam logic [2:0] S_FINISH   = 3'd5;  // hand the result to the output register

   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic             tst_start_ff, tst_start_in;
   logic [WIDTH-1:0] tst_val_ff, tst_val_in;
   logic             prime_ff, prime_in;
   logic             sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_prime_ff, rsp_prime_in;
   logic             rsp_sum_ff, rsp_sum_in;
   logic [WIDTH-1:0] p_next;
   logic             load_rsp;
   test_cmd_type     tst_cmd;
   test_res_type     tst_res;

   // One shared trial-division tester serves every primality question
   gpc_prime_test u_test (
      .clock    (clock),
      .reset    (reset),
      .test_cmd (tst_cmd),
      .test_res (tst_res)
   );

   assign tst_cmd.start = tst_start_ff;
   assign tst_cmd.value = tst_val_ff;

   // Candidate p never passes n/2 + 1, so the increment cannot wrap
   assign p_next   = p_ff + 1'b1;
   // Output register free, or being emptied this cycle
   assign load_rsp = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      tst_start_in = 1'b0;
      tst_val_in   = tst_val_ff;
      prime_in     = prime_ff;
      sum_in       = sum_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               // take the item and start testing n straight away
               n_in         = req_ch.number;
               tst_val_in   = req_ch.number;
               tst_start_in = 1'b1;
               state_in     = S_TEST_N;
            end
         end
         S_TEST_N: begin
            if (tst_res.done) begin
               prime_in = tst_res.is_prime;
               if (n_ff < WIDTH'(4)) begin
                  // no candidate p exists below four
                  sum_in   = 1'b0;
                  state_in = S_FINISH;
               end else if (n_ff[0]) begin
                  tst_val_in   = n_ff - WIDTH'(2);
                  tst_start_in = 1'b1;
                  state_in     = S_TEST_ODD;
               end else begin
                  p_in         = WIDTH'(2);
                  tst_val_in   = WIDTH'(2);
                  tst_start_in = 1'b1;
                  state_in     = S_TEST_P;
               end
            end
         end
         S_TEST_ODD: begin
            if (tst_res.done) begin
               sum_in   = tst_res.is_prime;
               state_in = S_FINISH;
            end
         end
         S_TEST_P, S_TEST_Q: begin
            if (tst_res.done) begin
               if (tst_res.is_prime && (state_ff == S_TEST_P)) begin
                  // p is prime: check its partner
                  tst_val_in   = n_ff - p_ff;
                  tst_start_in = 1'b1;
                  state_in     = S_TEST_Q;
               end else if (tst_res.is_prime) begin
                  sum_in   = 1'b1;
                  state_in = S_FINISH;
               end else if (p_next > {1'b0, n_ff[WIDTH-1:1]}) begin
                  // candidates exhausted
                  sum_in   = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  // advance to the next candidate
                  p_in         = p_next;
                  tst_val_in   = p_next;
                  tst_start_in = 1'b1;
                  state_in     = S_TEST_P;
               end
            end
         end
         S_FINISH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load from the sequencer, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = prime_ff;
         rsp_sum_in   = sum_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tst_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tst_start_ff <= tst_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      p_ff         <= p_in;
      tst_val_ff   <= tst_val_in;
      prime_ff     <= prime_in;
      sum_ff       <= sum_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_sum_ff   <= rsp_sum_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.number_is_prime  = rsp_prime_ff;
   assign rsp_ch.is_two_prime_sum = rsp_sum_ff;

`ifndef SYNTHESIS
   // A tester answer arrives only while a test is outstanding
   a_done_in_test: assert property (@(posedge clock) disable iff (reset)
      tst_res.done |-> (state_ff == S_TEST_N || state_ff == S_TEST_ODD ||
                        state_ff == S_TEST_P || state_ff == S_TEST_Q))
      else $error("prime tester answered outside a test state");

   // An accepted item starts the test of n in the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (tst_start_ff && state_ff == S_TEST_N))
      else $error("accepted item did not start a prime test");

   // A result appears only out of the finish state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside the finish state");

   // No new test is started while the tester is still answering the last one
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      tst_start_ff |-> !tst_res.done)
      else $error("prime test started while an answer was pending");
`endif

endmodule

`default_nettype wire

// ===== sv/gpc_rem_serial.sv =====
// gpc_rem_serial: bit-serial restoring remainder, one dividend bit per cycle.
// Depends on gpc_pkg.
`default_nettype none

module gpc_rem_serial import gpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type div_cmd,
   output div_res_type div_res
);

   logic [WIDTH-1:0] sh_ff, sh_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             zero_ff, zero_in;
   logic [D_W:0]     trial;
   logic [D_W:0]     diff;

   always_comb begin
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, sh_ff[WIDTH-1]};
      diff    = trial - {1'b0, div_ff};
      if (!busy_ff) begin
         if (div_cmd.start) begin
            sh_in   = div_cmd.dividend;
            rem_in  = '0;
            div_in  = div_cmd.divisor;
            cnt_in  = CNT_W'(WIDTH);
            busy_in = 1'b1;
         end
      end else begin
         // shift in the next dividend bit, subtract where it fits
         sh_in  = {sh_ff[WIDTH-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? diff[D_W-1:0] : trial[D_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      zero_in = (rem_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
   end

   assign div_res.done    = done_ff;
   assign div_res.is_zero = zero_ff;

endmodule

`default_nettype wire

// ===== sv/gpc_prime_test.sv =====
// gpc_prime_test: trial-division sequencer, walks d = 2, 3, ... while d*d <= x.
// Depends on gpc_pkg and gpc_rem_serial.
`default_nettype none

module gpc_prime_test import gpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  test_cmd_type test_cmd,
   output test_res_type test_res
);

   localparam logic [1:0] T_IDLE  = 2'd0;
   localparam logic [1:0] T_CHECK = 2'd1;
   localparam logic [1:0] T_DIV   = 2'd2;

   logic [1:0]       st_ff, st_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [D_W-1:0]   d_ff, d_in;
   logic [SQ_W-1:0]  dsq_ff, dsq_in;
   logic             go_ff, go_in;
   logic             done_ff, done_in;
   logic             prime_ff, prime_in;
   div_cmd_type      div_cmd;
   div_res_type      div_res;

   gpc_rem_serial u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_res (div_res)
   );

   assign div_cmd.start    = go_ff;
   assign div_cmd.dividend = x_ff;
   assign div_cmd.divisor  = d_ff;

   always_comb begin
      st_in    = st_ff;
      x_in     = x_ff;
      d_in     = d_ff;
      dsq_in   = dsq_ff;
      go_in    = 1'b0;
      done_in  = 1'b0;
      prime_in = prime_ff;
      case (st_ff)
         T_IDLE: begin
            if (test_cmd.start) begin
               x_in = test_cmd.value;
               if (test_cmd.value < WIDTH'(2)) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else begin
                  d_in   = D_W'(2);
                  dsq_in = SQ_W'(4);
                  st_in  = T_CHECK;
               end
            end
         end
         T_CHECK: begin
            if (dsq_ff > {{(SQ_W-WIDTH){1'b0}}, x_ff}) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
               st_in    = T_IDLE;
            end else begin
               go_in = 1'b1;
               st_in = T_DIV;
            end
         end
         T_DIV: begin
            if (div_res.done) begin
               if (div_res.is_zero) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
                  st_in    = T_IDLE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  d_in   = d_ff + 1'b1;
                  dsq_in = dsq_ff + SQ_W'({d_ff, 1'b1});
                  st_in  = T_CHECK;
               end
            end
         end
         default: begin
            st_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= T_IDLE;
         go_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         go_ff   <= go_in;
         done_ff <= done_in;
      end
      x_ff     <= x_in;
      d_ff     <= d_in;
      dsq_ff   <= dsq_in;
      prime_ff <= prime_in;
   end

   assign test_res.done     = done_ff;
   assign test_res.is_prime = prime_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_goldbach_partition_check_top.sv =====
// Testbench for goldbach_partition_check_top: primality and two-prime-sum flags per number.
// Depends on gpc_pkg, gpc_if and the block itself; self-checking with an in-bench predictor.
`default_nettype none

module tb_goldbach_partition_check_top;
   import gpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Idle limit: an odd number near the top of the range runs two long prime tests, and an
   // even one can chain several long tests, so allow plenty over that.
   localparam int unsigned WATCHDOG_LIMIT  = 200000;
   localparam int unsigned RANDOM_COUNT    = 600;
   localparam int unsigned QUIET_TAIL      = 100;   // last items run with no idling
   localparam int unsigned HOLD_OFF_AT     = 150;   // item index that triggers the hold-off
   // long enough for two of the slowest items to finish and back up the input
   localparam int unsigned HOLD_OFF_CYCLES = 25000;
   localparam int unsigned DRAIN_CYCLES    = 64;

   typedef struct packed {
      logic [WIDTH-1:0] number;
      logic             number_is_prime;
      logic             is_two_prime_sum;
   } flag_pair_type;

   // Scoreboard: predicts both flags for each accepted number and checks them in order.
   class partition_scoreboard;
      flag_pair_type expected_flags[$];
      int unsigned   error_count;
      int unsigned   checked_count;
      int unsigned   prime_count;
      int unsigned   two_sum_count;

      static function bit prime_by_division(int unsigned x);
         int unsigned d;
         if (x < 2) return 1'b0;
         for (d = 2; d * d <= x; d++) begin
            if (x % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      static function bit sum_of_two_primes(int unsigned x);
         int unsigned p;
         if (x < 4) return 1'b0;
         // odd sums need 2 as one of the primes
         if ((x & 1) != 0) return prime_by_division(x - 2);
         for (p = 2; p <= x / 2; p++) begin
            if (prime_by_division(p) && prime_by_division(x - p)) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_number(logic [WIDTH-1:0] n);
         flag_pair_type e;
         e.number           = n;
         e.number_is_prime  = prime_by_division(int'(n));
         e.is_two_prime_sum = sum_of_two_primes(int'(n));
         expected_flags.push_back(e);
      endfunction

      function void check_flags(logic got_prime, logic got_sum);
         flag_pair_type e;
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected result, expected none, got prime=%0b sum=%0b",
                     $time, got_prime, got_sum);
            error_count++;
            return;
         end
         e = expected_flags.pop_front();
         checked_count++;
         if (e.number_is_prime) prime_count++;
         if (e.is_two_prime_sum) two_sum_count++;
         if (got_prime !== e.number_is_prime) begin
            $display("%0t: number %0d number_is_prime expected %0b, actual %0b",
                     $time, e.number, e.number_is_prime, got_prime);
            error_count++;
         end
         if (got_sum !== e.is_two_prime_sum) begin
            $display("%0t: number %0d is_two_prime_sum expected %0b, actual %0b",
                     $time, e.number, e.is_two_prime_sum, got_sum);
            error_count++;
         end
      endfunction

      function int unsigned pending();
         return expected_flags.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   gpc_req_if req_ch ();
   gpc_rsp_if rsp_ch ();

   goldbach_partition_check_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   partition_scoreboard sb = new();

   bit          gaps_on          = 1'b1;
   bit          hold_off_pending = 1'b0;
   bit          hold_off_done    = 1'b0;
   int unsigned idle_cycles      = 0;

   // Edge cases: zero and one, the numbers below four, small odd sums through 2,
   // odd composites whose n-2 is composite, bit patterns and the top of the range.
   int unsigned corner_numbers[$] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 12, 27, 97, 99, 128, 255, 256,
      16'h5555, 16'hAAAA, 65521, 65523, 65531, 65534, 65535
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one number and hold it until the block takes it; the edge of
   // acceptance is the one this task returns on.
   task automatic send_number(input logic [WIDTH-1:0] n);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.number <= n;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Mostly small numbers keep the run short; a tenth spans the full range so
   // that every bit of the number toggles and long prime tests still occur.
   function automatic logic [WIDTH-1:0] pick_number();
      int unsigned tier;
      tier = $urandom_range(0, 9);
      if (tier < 7) return WIDTH'($urandom_range(0, 255));
      if (tier < 9) return WIDTH'($urandom_range(256, 4095));
      return WIDTH'($urandom_range(0, (1 << WIDTH) - 1));
   endfunction

   // Result sink: random short stalls, one long hold-off on request, steady ready otherwise.
   initial begin : result_sink
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            // hold ready low long enough for the block to fill and stall its input
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_pending = 1'b0;
            hold_off_done    = 1'b1;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Monitors: note accepted numbers, check accepted results.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) sb.note_number(req_ch.number);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_flags(rsp_ch.number_is_prime, rsp_ch.is_two_prime_sum);
   end

   // Watchdog: count cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout after %0d cycles with no item moving, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned i;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.number <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner numbers
      foreach (corner_numbers[k]) send_number(WIDTH'(corner_numbers[k]));

      // random numbers, with the long hold-off partway and a quiet tail
      for (i = 0; i < RANDOM_COUNT; i++) begin
         if (i == HOLD_OFF_AT) hold_off_pending = 1'b1;
         if (i == RANDOM_COUNT - QUIET_TAIL) gaps_on = 1'b0;
         send_number(pick_number());
      end
      req_ch.valid <= 1'b0;

      // drain, then give the block a margin to show any stray result
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d numbers (%0d prime, %0d sums of two primes), corners plus random",
               sb.checked_count, sb.prime_count, sb.two_sum_count);
      $display("Idle bursts on both sides, receiver hold-off of %0d cycles %s",
               HOLD_OFF_CYCLES, hold_off_done ? "applied" : "not reached");
      if (sb.error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
